>>> rtl/cbpg_pkg.sv
// cbpg_pkg: shared constants, types and the blending weight table of the
// cubic b-spline point generator. No dependencies; used by every rtl file.
`default_nettype none

package cbpg_pkg;

  // coordinate and curve formats
  localparam int COORD_BITS = 11;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_W      = COORD_BITS + FRAC_BITS;

  // segments per window, a power of two from 1 to 32
  localparam int SEG_LOG2 = 5;
  localparam int SEGMENTS = 1 << SEG_LOG2;
  localparam int IDX_W    = SEG_LOG2 + 1;

  // weights are scaled by 6*SEGMENTS^3 = 3 * 2^(3*SEG_LOG2+1)
  localparam int W_W   = 3 * SEG_LOG2 + 3;
  localparam int NUM_W = W_W + COORD_BITS;
  localparam int SHIFT = 3 * SEG_LOG2 + 1;
  localparam int Q_W   = NUM_W + FRAC_BITS - SHIFT;
  localparam int R_W   = Q_W + 2;

  localparam logic [NUM_W+FRAC_BITS-1:0] HALF_DENOM =
    (NUM_W + FRAC_BITS)'(64'd3 << (3 * SEG_LOG2));
  localparam logic [R_W-1:0] RECIP3 = R_W'((64'd1 << R_W) / 3);
  localparam logic [OUT_W-1:0] OUT_MAX =
    OUT_W'(((64'd1 << COORD_BITS) - 1) << FRAC_BITS);

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [3:0][W_W-1:0] wset_t;
  typedef wset_t [SEGMENTS:0] wtab_t;

  // controller to datapath
  typedef struct packed {
    logic             shift_win;
    logic             load_work;
    logic             issue;
    logic [IDX_W-1:0] idx;
    logic             last;
  } cbpg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic adv;
  } cbpg_sts_t;

  function automatic wtab_t build_weights();
    wtab_t  tab;
    longint s;
    longint s2;
    longint s3;
    longint u;
    longint i2;
    longint i3;
    s  = SEGMENTS;
    s2 = s * s;
    s3 = s2 * s;
    for (int i = 0; i <= SEGMENTS; i++) begin
      u  = s - i;
      i2 = longint'(i) * i;
      i3 = i2 * i;
      tab[i][0] = W_W'(u * u * u);
      tab[i][1] = W_W'(3 * i3 + 4 * s3 - 6 * i2 * s);
      tab[i][2] = W_W'(3 * i2 * s + 3 * longint'(i) * s2 + s3 - 3 * i3);
      tab[i][3] = W_W'(i3);
    end
    return tab;
  endfunction

  localparam wtab_t WEIGHT_TAB = build_weights();

endpackage

`default_nettype wire

>>> rtl/cbpg_ctrl.sv
// cbpg_ctrl: warm-up counter and the state machine that walks the curve
// index for one window. Depends on cbpg_pkg.
`default_nettype none

module cbpg_ctrl
  import cbpg_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  wire cbpg_sts_t sts_i,
  output cbpg_cmd_t      cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [1:0]       SEEN_FULL = 2'd3;
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SEGMENTS);

  logic             state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [1:0]       seen_q, seen_d;
  logic             accept;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    seen_d  = seen_q;
    if (accept && (seen_q != SEEN_FULL)) begin
      seen_d = seen_q + 2'd1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (seen_q == SEEN_FULL)) begin
          state_d = ST_RUN;
          idx_d   = '0;
        end
      end
      ST_RUN: begin
        if (sts_i.adv) begin
          if (idx_q == IDX_LAST) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      seen_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      seen_q  <= seen_d;
    end
  end

  assign cmd_o.shift_win = accept;
  assign cmd_o.load_work = accept && (seen_q == SEEN_FULL);
  assign cmd_o.issue     = (state_q == ST_RUN) && sts_i.adv;
  assign cmd_o.idx       = idx_q;
  assign cmd_o.last      = (idx_q == IDX_LAST);

  // a run only starts once the window is full
  a_run_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (seen_q == SEEN_FULL))
    else $error("curve run without a full window");

  // a stalled pipeline holds the curve index
  a_idx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && !sts_i.adv) |=> ((state_q == ST_RUN) && $stable(idx_q)))
    else $error("curve index moved during a stall");

  // issuing the last index ends the run
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && sts_i.adv && (idx_q == IDX_LAST)) |=> (state_q == ST_IDLE))
    else $error("run did not end after the last index");

endmodule

`default_nettype wire

>>> rtl/cbpg_datapath.sv
// cbpg_datapath: point window, four-point working set, blend pipeline
// (multiply, sum and round, divide by three) and the output register.
// Depends on cbpg_pkg.
`default_nettype none

module cbpg_datapath
  import cbpg_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  wire cbpg_cmd_t              cmd_i,
  output cbpg_sts_t                   sts_o,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                        m_axis_tlast_o
);

  // lane 0 is x, lane 1 is y
  coord_t [1:0]             pt_in;
  coord_t [1:0][2:0]        win_q;
  coord_t [1:0][3:0]        work_q;
  logic   [1:0][3:0][NUM_W-1:0] prod_q;
  logic   [1:0][Q_W-1:0]    scl_q;
  logic   [1:0][Q_W-1:0]    x3_q;
  logic   [1:0][Q_W-1:0]    q0_q;
  logic   [1:0][OUT_W-1:0]  res;
  logic   [1:0][OUT_W-1:0]  out_q;
  logic   [1:0][Q_W+1:0]    tri_q0;
  logic   [1:0][Q_W+1:0]    x3_ext;
  logic   [1:0][NUM_W-1:0]  sum;
  logic   [1:0][NUM_W+FRAC_BITS-1:0] rnd;
  logic   [1:0][Q_W+R_W-1:0] rmul;
  logic   [1:0]             corr;
  wset_t                    w;
  logic                     v1_q, v2_q, v3_q, out_valid_q;
  logic                     l1_q, l2_q, l3_q, out_last_q;
  logic                     adv;

  assign pt_in[0] = s_axis_tdata_i[COORD_BITS-1:0];
  assign pt_in[1] = s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];

  // whole pipeline moves when the output register is free or being taken
  assign adv       = !out_valid_q || m_axis_tready_i;
  assign sts_o.adv = adv;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (cmd_i.shift_win) begin
        win_q[l][0] <= win_q[l][1];
        win_q[l][1] <= win_q[l][2];
        win_q[l][2] <= pt_in[l];
      end
      if (cmd_i.load_work) begin
        work_q[l] <= {pt_in[l], win_q[l][2], win_q[l][1], win_q[l][0]};
      end
    end
  end

  assign w = WEIGHT_TAB[cmd_i.idx];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum[l] = prod_q[l][0] + prod_q[l][1] + prod_q[l][2] + prod_q[l][3];
      rnd[l] = {sum[l], {FRAC_BITS{1'b0}}} + HALF_DENOM;
      rmul[l] = (Q_W + R_W)'(scl_q[l]) * (Q_W + R_W)'(RECIP3);
      tri_q0[l] = {2'b00, q0_q[l]} + {1'b0, q0_q[l], 1'b0};
      x3_ext[l] = {2'b00, x3_q[l]};
      // reciprocal estimate is low by at most one
      corr[l] = (x3_ext[l] >= (tri_q0[l] + (Q_W + 2)'(3)));
      res[l] = OUT_W'(q0_q[l] + Q_W'(corr[l]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < 4; k++) begin
          prod_q[l][k] <= NUM_W'(w[k]) * NUM_W'(work_q[l][k]);
        end
        scl_q[l] <= rnd[l][NUM_W+FRAC_BITS-1:SHIFT];
        x3_q[l]  <= scl_q[l];
        q0_q[l]  <= rmul[l][Q_W+R_W-1:R_W];
        out_q[l] <= res[l];
      end
      l1_q       <= cmd_i.last;
      l2_q       <= l1_q;
      l3_q       <= l2_q;
      out_last_q <= l3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= cmd_i.issue;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_q[1], out_q[0]});

  // blended points stay inside the control point range
  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q[0] <= OUT_MAX))
    else $error("curve x out of range");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q[1] <= OUT_MAX))
    else $error("curve y out of range");

  // divide-by-three remainder before correction is below six
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> ((x3_ext[0] >= tri_q0[0]) && (x3_ext[0] < tri_q0[0] + (Q_W + 2)'(6)) &&
              (x3_ext[1] >= tri_q0[1]) && (x3_ext[1] < tri_q0[1] + (Q_W + 2)'(6))))
    else $error("reciprocal divide estimate out of bounds");

endmodule

`default_nettype wire

>>> rtl/cubic_bspline_point_generator.sv
// cubic_bspline_point_generator: top level, joins the controller and the
// datapath. Depends on cbpg_pkg, cbpg_ctrl and cbpg_datapath.
//
// usage:
//   the slave stream takes 2-D control points, one per request. the first
//   three only fill the point window and give no output. every later point
//   closes a window of four and starts a run of SEGMENTS+1 curve points,
//   t = i/SEGMENTS for i = 0..SEGMENTS, on the master stream; tlast marks
//   the point with i = SEGMENTS.
//   pipeline: the first curve point of a run passes the multiply, sum and
//   round, reciprocal multiply and output register stages; the run then
//   follows at one curve point per cycle while the master side does not stall.
//   the single blend pipeline sets the control point rate: a new control
//   point is taken only once the run of the last one has been issued;
//   warm-up points are taken as they arrive.
//   tready on the slave side stays low while a run is being issued.
//   a stall on the master side freezes the whole blend pipeline; nothing
//   is dropped and the run resumes when tready returns.
//   reset empties the pipeline and the window count; the next three
//   points are warm-up again.
`default_nettype none

module cubic_bspline_point_generator
  import cbpg_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // point_x, point_y, zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // curve_x, curve_y, zero pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // last_point
  output logic                        m_axis_tlast_o
);

  cbpg_cmd_t cmd;
  cbpg_sts_t sts;

  cbpg_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  cbpg_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
